// File: rtl/rrle_pkg.sv
// Shared types and constants for the row run-length encoder.
package rrle_pkg;

  localparam int CFG_W = 11;
  localparam int PIX_W = 8;
  localparam int LEN_W = 8;

  localparam logic [LEN_W-1:0] RUN_LIMIT = 8'd255;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_LINE_WIDTH   = 1'b0;
  localparam cfg_index_t REG_FRAME_HEIGHT = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic             brk_valid;
    logic [PIX_W-1:0] brk_value;
    logic [LEN_W-1:0] brk_len;
    logic             flush_valid;
    logic [PIX_W-1:0] flush_value;
    logic [LEN_W-1:0] flush_len;
    logic             frame_end;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

// File: rtl/row_run_length_encoder_unit.sv
// Row run-length encoder top level: (value, run length) records from raster pixels.
// Takes one pixel per clock while full is low and writes one record per clock,
// when the output is empty or popped, to a single output word register. A pixel
// causes zero, one or two records (a broken run, then a row flush); its job passes
// through a four-entry queue, which absorbs the extra record of a two-record pixel.
// full rises only when that queue holds four jobs. Runs end at every row end and
// at 255 pixels. line_width and frame_height read 0 as 1 and clamp to
// MAX_WIDTH and MAX_HEIGHT.
module row_run_length_encoder_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  rrle_pkg::cfg_index_t       cfg_index,
  input  logic [rrle_pkg::CFG_W-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [rrle_pkg::PIX_W-1:0] pixel,
  output logic                       empty,
  input  logic                       pop,
  output logic [rrle_pkg::PIX_W-1:0] value,
  output logic [rrle_pkg::LEN_W-1:0] run_length,
  output logic                       row_end,
  output logic                       frame_end,
  output logic                       last_of_item
);
  import rrle_pkg::*;

  job_t   in_job;
  job_t   head_job;
  logic   job_push;
  logic   job_pop;
  qstat_t qstat;

  assign full = qstat.full;

  rrle_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .pixel     (pixel),
    .qstat     (qstat),
    .job_push  (job_push),
    .job       (in_job)
  );

  rrle_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (in_job),
    .rd     (job_pop),
    .rd_job (head_job),
    .qstat  (qstat)
  );

  rrle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .job          (head_job),
    .job_pop      (job_pop),
    .pop          (pop),
    .empty        (empty),
    .value        (value),
    .run_length   (run_length),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .last_of_item (last_of_item)
  );

endmodule

// File: rtl/rrle_front.sv
// Front end: configuration registers, run tracking and record classification.
module rrle_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  rrle_pkg::cfg_index_t       cfg_index,
  input  logic [rrle_pkg::CFG_W-1:0] cfg_data,
  input  logic                       push,
  input  logic [rrle_pkg::PIX_W-1:0] pixel,
  input  rrle_pkg::qstat_t           qstat,
  output logic                       job_push,
  output rrle_pkg::job_t             job
);
  import rrle_pkg::*;

  localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RIW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HW  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] frame_height;
  logic [PIX_W-1:0] run_value;
  logic [LEN_W-1:0] run_count;
  logic [CIW-1:0]   column_index;
  logic [RIW-1:0]   row_index;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic             take;
  logic             extend;
  logic             brk_valid;
  logic             row_done;
  logic             last_row;
  logic [PIX_W-1:0] run_value_next;
  logic [LEN_W-1:0] run_count_next;

  always_comb begin
    if (line_width == '0) begin
      w_eff = WW'(1);
    end else if (WW'(line_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(line_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (HW'(frame_height) > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  assign take      = push && !qstat.full;
  assign extend    = (run_count != '0) && (pixel == run_value) && (run_count != RUN_LIMIT);
  assign brk_valid = !extend && (run_count != '0);
  assign row_done  = (WW'(column_index) + WW'(1)) >= w_eff;
  assign last_row  = (HW'(row_index) + HW'(1)) >= h_eff;

  assign run_value_next = extend ? run_value : pixel;
  assign run_count_next = extend ? run_count + LEN_W'(1) : LEN_W'(1);

  assign job_push = take && (brk_valid || row_done);

  always_comb begin
    job.brk_valid   = brk_valid;
    job.brk_value   = run_value;
    job.brk_len     = run_count;
    job.flush_valid = row_done;
    job.flush_value = run_value_next;
    job.flush_len   = run_count_next;
    job.frame_end   = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= SIZE_RESET;
      frame_height <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:   line_width   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value    <= '0;
      run_count    <= '0;
      column_index <= '0;
      row_index    <= '0;
    end else if (take) begin
      run_value <= run_value_next;
      if (row_done) begin
        run_count    <= '0;
        column_index <= '0;
        row_index    <= last_row ? '0 : RIW'(row_index + 1'b1);
      end else begin
        run_count    <= run_count_next;
        column_index <= CIW'(column_index + 1'b1);
      end
    end
  end

endmodule

// File: rtl/rrle_queue.sv
// Short job queue between front end and back end.
module rrle_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  rrle_pkg::job_t   wr_job,
  input  logic             rd,
  output rrle_pkg::job_t   rd_job,
  output rrle_pkg::qstat_t qstat
);
  import rrle_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign qstat.valid = (count != '0);
  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign do_wr       = wr && !qstat.full;
  assign do_rd       = rd && qstat.valid;
  assign rd_job      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/rrle_back.sv
// Back end: splits each job into records and holds the output word.
module rrle_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rrle_pkg::qstat_t           qstat,
  input  rrle_pkg::job_t             job,
  output logic                       job_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [rrle_pkg::PIX_W-1:0] value,
  output logic [rrle_pkg::LEN_W-1:0] run_length,
  output logic                       row_end,
  output logic                       frame_end,
  output logic                       last_of_item
);
  import rrle_pkg::*;

  logic out_valid;
  logic phase;
  logic load;
  logic send_brk;

  assign empty    = !out_valid;
  assign load     = !out_valid || pop;
  assign send_brk = job.brk_valid && !phase;
  assign job_pop  = load && qstat.valid && !(send_brk && job.flush_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= qstat.valid;
      if (qstat.valid) begin
        phase <= send_brk && job.flush_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && qstat.valid) begin
      if (send_brk) begin
        value        <= job.brk_value;
        run_length   <= job.brk_len;
        row_end      <= 1'b0;
        frame_end    <= 1'b0;
        last_of_item <= !job.flush_valid;
      end else begin
        value        <= job.flush_value;
        run_length   <= job.flush_len;
        row_end      <= 1'b1;
        frame_end    <= job.frame_end;
        last_of_item <= 1'b1;
      end
    end
  end

  a_frame_has_row: assert property (@(posedge clk) disable iff (rst)
    !empty && frame_end |-> row_end)
    else $error("frame_end without row_end");

  a_row_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && row_end |-> last_of_item)
    else $error("row flush not marked last");

  a_phase_holds_job: assert property (@(posedge clk) disable iff (rst)
    phase |-> qstat.valid && job.flush_valid)
    else $error("second record pending without its job");

endmodule
